// ===== design/priority_task_scheduler_semaphores_top_macros.svh =====
// Assertion macros shared by the scheduler RTL.
`ifndef PRIORITY_TASK_SCHEDULER_SEMAPHORES_TOP_MACROS_SVH
`define PRIORITY_TASK_SCHEDULER_SEMAPHORES_TOP_MACROS_SVH

// Check a property at every clock edge outside reset.
`define PTSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence at the following edge.
`define PTSS_ASSERT_NEXT(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ptss_pkg.sv =====
// Types and constants shared by the scheduler modules.
`timescale 1ns / 1ps
`default_nettype none
package ptss_pkg;

    localparam int NUM_TASK_SLOTS = 8;
    localparam int NUM_SEMAPHORES = 16;
    localparam int TASK_W         = $clog2(NUM_TASK_SLOTS);
    localparam int SEM_W          = $clog2(NUM_SEMAPHORES);
    localparam int TIME_W         = 32;
    localparam int OP_W           = 3;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 3'd0,
        OP_CREATE  = 3'd1,
        OP_TAKE    = 3'd2,
        OP_GIVE    = 3'd3,
        OP_DELAY   = 3'd4,
        OP_RESCHED = 3'd5
    } t_op;

    // Per-cell update request from the sequencer.
    typedef struct packed {
        logic              enable;   // cell takes part in the searches
        logic              clear;
        logic              block;
        logic              unblock;
        logic              set_rel;
        logic [SEM_W-1:0]  sem;
        logic [TIME_W-1:0] rel;
    } t_cell_cmd;

    // Search flags passed from lower-index cells to higher-index cells.
    typedef struct packed {
        logic wait_seen;
        logic ready_seen;
    } t_chain;

    // What a cell reports back: first match of each search.
    typedef struct packed {
        logic wait_first;
        logic ready_first;
    } t_hit;

endpackage
`default_nettype wire

// ===== design/ptss_cell.sv =====
// One task slot: release tick, blocked flag, waited semaphore and search step.
`timescale 1ns / 1ps
`default_nettype none
module ptss_cell import ptss_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cell_cmd         i_cmd,
    input  wire logic [TIME_W-1:0] i_tick,
    input  wire t_chain            i_chain,
    output t_chain                 o_chain,
    output t_hit                   o_hit
);

    logic [TIME_W-1:0] r_release;
    logic              r_blocked;
    logic [SEM_W-1:0]  r_waits_on;
    logic              ready;
    logic              waiting;
    logic              wait_first;

    // Slot state updates; an unblock request only frees the first waiter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_release  <= '0;
            r_blocked  <= 1'b0;
            r_waits_on <= '0;
        end else if (i_cmd.clear) begin
            r_release  <= '0;
            r_blocked  <= 1'b0;
            r_waits_on <= '0;
        end else begin
            if (i_cmd.block) begin
                r_blocked  <= 1'b1;
                r_waits_on <= i_cmd.sem;
            end else if (i_cmd.unblock && wait_first) begin
                r_blocked <= 1'b0;
            end
            if (i_cmd.set_rel) begin
                r_release <= i_cmd.rel;
            end
        end
    end

    // Local match terms and the priority ripple to the next cell.
    assign ready      = i_cmd.enable && (i_tick >= r_release) && !r_blocked;
    assign waiting    = i_cmd.enable && r_blocked && (r_waits_on == i_cmd.sem);
    assign wait_first = waiting && !i_chain.wait_seen;

    assign o_hit.ready_first  = ready && !i_chain.ready_seen;
    assign o_hit.wait_first   = wait_first;
    assign o_chain.ready_seen = i_chain.ready_seen || ready;
    assign o_chain.wait_seen  = i_chain.wait_seen || waiting;

endmodule
`default_nettype wire

// ===== design/priority_task_scheduler_semaphores_top.sv =====
// Top level of the fixed-priority task scheduler with binary semaphores.
//
// Input channel: one kernel event per beat (op, task_id, sem_id, resume tick,
// period), accepted when i_in_valid is high and o_in_stall is low.
// Output channel: one result beat per event (running_task, granted, switched,
// next_release), taken when o_out_valid is high and i_out_stall is low.
// Each event goes through accept, update of the task cells with the waiter
// search, then the ready search through the cell chain that writes the
// result register. A new event is accepted only after the last one has
// written its result; the ripple through the row of task cells sets the path.
// A stalled output holds its beat and the sequencer waits in its last step,
// so the input stalls until the result register frees up.
// Reset clears the tick count, all task slots and all semaphores, and makes
// the idle task 0 the running task; no pass over the state is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "priority_task_scheduler_semaphores_top_macros.svh"
module priority_task_scheduler_semaphores_top import ptss_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [OP_W-1:0]   i_op,
    input  wire logic [TASK_W-1:0] i_task_id,
    input  wire logic [SEM_W-1:0]  i_sem_id,
    input  wire logic [TIME_W-1:0] i_resume_tick,
    input  wire logic [TIME_W-1:0] i_period,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [TASK_W-1:0]      o_running_task,
    output logic                   o_granted,
    output logic                   o_switched,
    output logic [TIME_W-1:0]      o_next_release
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCHED
    } t_state;

    t_state              r_state;
    logic [OP_W-1:0]     r_op;
    logic [TASK_W-1:0]   r_tid;
    logic [SEM_W-1:0]    r_sem;
    logic [TIME_W-1:0]   r_rel;
    logic [TIME_W-1:0]   r_per;
    logic [TIME_W-1:0]   r_tick;
    logic [TASK_W-1:0]   r_cur;
    logic [NUM_SEMAPHORES-1:0] r_sem_taken;
    logic                r_granted;
    logic                r_resched;
    logic [TIME_W-1:0]   r_next;
    logic                r_out_valid;
    logic [TASK_W-1:0]   r_out_task;
    logic                r_out_granted;
    logic                r_out_switched;
    logic [TIME_W-1:0]   r_out_next;

    logic [TIME_W-1:0]   n_tick;
    logic [NUM_SEMAPHORES-1:0] n_sem_taken;
    logic                n_granted;
    logic                n_resched;
    logic [TIME_W-1:0]   n_next;
    logic                n_out_valid;

    t_cell_cmd           cmd   [NUM_TASK_SLOTS];
    t_chain              chain [NUM_TASK_SLOTS+1];
    t_hit                hit   [NUM_TASK_SLOTS];
    logic [NUM_TASK_SLOTS-1:0] ready_vec;
    logic [NUM_TASK_SLOTS-1:0] wait_vec;
    logic [TASK_W-1:0]   pick_idx;
    logic [TASK_W-1:0]   waiter_idx;
    logic                waiter_found;
    logic                exec;
    logic                out_free;
    t_op                 op;

    assign op       = t_op'(r_op);
    assign exec     = (r_state == ST_EXEC);
    assign out_free = !r_out_valid || !i_out_stall;

    // Update requests for each slot, issued in the execute step.
    always_comb begin
        for (int i = 0; i < NUM_TASK_SLOTS; i++) begin
            cmd[i].enable  = (i != 0);
            cmd[i].clear   = exec && (op == OP_CREATE) && (r_tid == TASK_W'(i));
            cmd[i].block   = exec && (op == OP_TAKE) && r_sem_taken[r_sem]
                             && (r_cur == TASK_W'(i));
            cmd[i].unblock = exec && (op == OP_GIVE);
            cmd[i].set_rel = exec && (op == OP_DELAY) && (r_cur == TASK_W'(i));
            cmd[i].sem     = r_sem;
            cmd[i].rel     = r_rel;
        end
    end

    // Row of task cells with the priority ripple between neighbors.
    assign chain[0] = '0;
    for (genvar g = 0; g < NUM_TASK_SLOTS; g++) begin : g_cell
        ptss_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd[g]),
            .i_tick  (r_tick),
            .i_chain (chain[g]),
            .o_chain (chain[g+1]),
            .o_hit   (hit[g])
        );
        assign ready_vec[g] = hit[g].ready_first;
        assign wait_vec[g]  = hit[g].wait_first;
    end

    // Encode the one-hot first matches into slot numbers.
    always_comb begin
        pick_idx   = '0;
        waiter_idx = '0;
        for (int i = 0; i < NUM_TASK_SLOTS; i++) begin
            if (ready_vec[i]) pick_idx = pick_idx | TASK_W'(i);
            if (wait_vec[i])  waiter_idx = waiter_idx | TASK_W'(i);
        end
    end
    assign waiter_found = chain[NUM_TASK_SLOTS].wait_seen;

    // Shared kernel state and event flags for the execute step.
    always_comb begin
        n_tick      = r_tick;
        n_sem_taken = r_sem_taken;
        n_granted   = r_granted;
        n_resched   = r_resched;
        n_next      = r_next;
        if (exec) begin
            n_granted = 1'b0;
            n_resched = 1'b0;
            n_next    = '0;
            case (op)
                OP_TICK: begin
                    n_tick    = r_tick + 1'b1;
                    n_resched = 1'b1;
                end
                OP_TAKE: begin
                    if (!r_sem_taken[r_sem]) begin
                        n_sem_taken[r_sem] = 1'b1;
                        n_granted          = 1'b1;
                    end else begin
                        n_resched = 1'b1;
                    end
                end
                OP_GIVE: begin
                    if (!waiter_found) begin
                        n_sem_taken[r_sem] = 1'b0;
                    end else begin
                        n_sem_taken[r_sem] = 1'b1;
                        if (waiter_idx < r_cur) begin
                            n_resched = 1'b1;
                        end
                    end
                end
                OP_DELAY: begin
                    n_next    = r_rel + r_per;
                    n_resched = 1'b1;
                end
                OP_RESCHED: begin
                    n_resched = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // The result register fills in the schedule step and empties when taken.
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if ((r_state == ST_SCHED) && out_free) begin
            n_out_valid = 1'b1;
        end
    end

    // Event sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_op           <= '0;
            r_tid          <= '0;
            r_sem          <= '0;
            r_rel          <= '0;
            r_per          <= '0;
            r_tick         <= '0;
            r_cur          <= '0;
            r_sem_taken    <= '0;
            r_out_valid    <= 1'b0;
            r_granted      <= 1'b0;
            r_resched      <= 1'b0;
            r_next         <= '0;
            r_out_task     <= '0;
            r_out_granted  <= 1'b0;
            r_out_switched <= 1'b0;
            r_out_next     <= '0;
        end else begin
            r_tick      <= n_tick;
            r_sem_taken <= n_sem_taken;
            r_granted   <= n_granted;
            r_resched   <= n_resched;
            r_next      <= n_next;
            r_out_valid <= n_out_valid;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_op;
                        r_tid   <= i_task_id;
                        r_sem   <= i_sem_id;
                        r_rel   <= i_resume_tick;
                        r_per   <= i_period;
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_state <= ST_SCHED;
                end
                ST_SCHED: begin
                    if (out_free) begin
                        r_out_task     <= r_resched ? pick_idx : r_cur;
                        r_out_granted  <= r_granted;
                        r_out_switched <= r_resched;
                        r_out_next     <= r_next;
                        if (r_resched) begin
                            r_cur <= pick_idx;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_running_task = r_out_task;
    assign o_granted      = r_out_granted;
    assign o_switched     = r_out_switched;
    assign o_next_release = r_out_next;

    // The ripple gives at most one first match per search, never the idle slot.
    `PTSS_ASSERT(a_ready_onehot, $onehot0(ready_vec) && !ready_vec[0], "two ready picks")
    `PTSS_ASSERT(a_wait_onehot, $onehot0(wait_vec) && !wait_vec[0], "two waiter picks")
    // A grant never comes with a reschedule.
    `PTSS_ASSERT(a_grant_switch, !(r_out_valid && r_out_granted && r_out_switched),
        "grant with switch")
    // An event always reaches the schedule step right after execute.
    `PTSS_ASSERT_NEXT(a_exec_next, r_state == ST_EXEC, r_state == ST_SCHED,
        "execute step not followed by schedule step")

endmodule
`default_nettype wire
